>>> rtl/core/omdpi_pkg.sv
package omdpi_pkg;

   // Shared multiplier operand and product widths.
   localparam int unsigned MUL_W  = 33;
   localparam int unsigned PROD_W = 66;

   // cos(30 deg) in unsigned Q0.16.
   localparam logic [15:0] COS30_Q16 = 16'd56756;

   // Anti-windup reload values, 0.01 in Q16.16.
   localparam logic signed [31:0] WINDUP_POS = 32'sd655;
   localparam logic signed [31:0] WINDUP_NEG = -32'sd655;

   // Plus and minus one in Q32.32, on the product width.
   localparam logic signed [PROD_W-1:0] ONE_Q32     = 66'sd4294967296;
   localparam logic signed [PROD_W-1:0] NEG_ONE_Q32 = -66'sd4294967296;

   // Limits of the signed 32-bit range, on the product width.
   localparam logic signed [PROD_W-1:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [PROD_W-1:0] SAT_LO = -66'sd2147483648;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_KIN,
      ST_WHEEL,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      REG_PROP_GAIN   = 3'd0,
      REG_INTEG_GAIN  = 3'd1,
      REG_TICK_PERIOD = 3'd2,
      REG_PWM_TOP     = 3'd3,
      REG_RADIUS      = 3'd4,
      REG_INV_CIRC    = 3'd5,
      REG_COUNT_SCALE = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [30:0] prop_gain;
      logic [30:0] integ_gain;
      logic [15:0] tick_period;
      logic [15:0] pwm_top;
      logic [15:0] base_radius;
      logic [30:0] inv_wheel_circumference;
      logic [30:0] count_scale;
   } cfg_type;

   // Saturate a wide signed value to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) begin
         r = 32'sh7FFFFFFF;
      end else if (v < SAT_LO) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/core/omdpi_mul.sv
module omdpi_mul
   import omdpi_pkg::*;
(
   input  logic                     clock,
   input  logic signed [MUL_W-1:0]  op_a,
   input  logic signed [MUL_W-1:0]  op_b,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   // Signed multiply; the product is registered and used in the following cycle.
   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

>>> rtl/core/omdpi_csr.sv
module omdpi_csr
   import omdpi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_sel;
   logic          write_en;

   assign reg_sel    = reg_index_type'(csr_paddr[4:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // Register writes; an address past the last register is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_sel)
            REG_PROP_GAIN:   cfg_in.prop_gain = csr_pwdata[30:0];
            REG_INTEG_GAIN:  cfg_in.integ_gain = csr_pwdata[30:0];
            REG_TICK_PERIOD: cfg_in.tick_period = csr_pwdata[15:0];
            REG_PWM_TOP:     cfg_in.pwm_top = csr_pwdata[15:0];
            REG_RADIUS:      cfg_in.base_radius = csr_pwdata[15:0];
            REG_INV_CIRC:    cfg_in.inv_wheel_circumference = csr_pwdata[30:0];
            REG_COUNT_SCALE: cfg_in.count_scale = csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain               <= 31'd65536;
         cfg_ff.integ_gain              <= 31'd0;
         cfg_ff.tick_period             <= 16'd655;
         cfg_ff.pwm_top                 <= 16'd999;
         cfg_ff.base_radius             <= 16'd6554;
         cfg_ff.inv_wheel_circumference <= 31'd327680;
         cfg_ff.count_scale             <= 31'd655;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back.
   always_comb begin
      unique case (reg_sel)
         REG_PROP_GAIN:   csr_prdata = 32'(cfg_ff.prop_gain);
         REG_INTEG_GAIN:  csr_prdata = 32'(cfg_ff.integ_gain);
         REG_TICK_PERIOD: csr_prdata = 32'(cfg_ff.tick_period);
         REG_PWM_TOP:     csr_prdata = 32'(cfg_ff.pwm_top);
         REG_RADIUS:      csr_prdata = 32'(cfg_ff.base_radius);
         REG_INV_CIRC:    csr_prdata = 32'(cfg_ff.inv_wheel_circumference);
         REG_COUNT_SCALE: csr_prdata = 32'(cfg_ff.count_scale);
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/omni_drive_pi_motor_control.sv
// Three-wheel omni drive with one PI velocity loop per wheel, Q16.16.
//
// The req_ channel takes one word per control tick: the chassis velocity
// command and the three encoder counts. The rsp_ channel gives one word per
// tick: a PWM compare value and a direction bit per wheel, and the measured
// wheel speeds. Both channels move a word on a clock edge where valid is high
// and stall is low. The user sets gains, period, PWM top, chassis radius and
// scale factors over csr_ only while idle; the block does not check this.
//
// All products go through one registered 33x33 signed multiplier under a
// step sequencer: 10 steps of kinematics and scaling, then 10 steps for each
// of the three wheels. A word is taken at the first clock edge with req_valid
// high and the block idle; after the steps and a done state, rsp_valid rises
// when the result is loaded into the output register. The block takes no new
// word until idle again: req_stall is high while a word is being worked on.
//
// A finished result waits in the output register while rsp_stall is high;
// the next word can be taken meanwhile, and its result waits until the
// output register is free. Reset clears the three integrators, restores the
// register defaults and drops rsp_valid.
module omni_drive_pi_motor_control
   import omdpi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_cmd_vx,
   input  logic signed [31:0] req_cmd_vy,
   input  logic signed [31:0] req_cmd_turn,
   input  logic signed [15:0] req_count_front,
   input  logic signed [15:0] req_count_left,
   input  logic signed [15:0] req_count_right,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [16:0]        rsp_duty_front,
   output logic               rsp_dir_front,
   output logic [16:0]        rsp_duty_left,
   output logic               rsp_dir_left,
   output logic [16:0]        rsp_duty_right,
   output logic               rsp_dir_right,
   output logic signed [31:0] rsp_speed_front,
   output logic signed [31:0] rsp_speed_left,
   output logic signed [31:0] rsp_speed_right,

   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   // Kinematics steps.
   localparam logic [3:0] K_ROT    = 4'd0;
   localparam logic [3:0] K_SIDE   = 4'd1;
   localparam logic [3:0] K_WVEL   = 4'd2;
   localparam logic [3:0] K_TGT0   = 4'd3;
   localparam logic [3:0] K_TGT1   = 4'd4;
   localparam logic [3:0] K_TGT2   = 4'd5;
   localparam logic [3:0] K_SPD0   = 4'd6;
   localparam logic [3:0] K_SPD1   = 4'd7;
   localparam logic [3:0] K_SPD2   = 4'd8;
   localparam logic [3:0] K_LAST   = 4'd9;

   // Per-wheel steps.
   localparam logic [3:0] W_ERR    = 4'd0;
   localparam logic [3:0] W_ETP    = 4'd1;
   localparam logic [3:0] W_ACC    = 4'd2;
   localparam logic [3:0] W_IP     = 4'd3;
   localparam logic [3:0] W_WINDUP = 4'd4;
   localparam logic [3:0] W_ITERM  = 4'd5;
   localparam logic [3:0] W_PERR   = 4'd6;
   localparam logic [3:0] W_DRIVE  = 4'd7;
   localparam logic [3:0] W_DUTY   = 4'd8;
   localparam logic [3:0] W_LAST   = 4'd9;

   localparam logic [1:0] LAST_WHEEL = 2'd2;

   cfg_type                  cfg;
   logic signed [MUL_W-1:0]  op_a;
   logic signed [MUL_W-1:0]  op_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] prod_sh16;

   state_type state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic [1:0] wheel_ff, wheel_in;
   logic       accept;
   logic       load_out;

   logic signed [31:0] vx_ff, vx_in;
   logic signed [31:0] vy_ff, vy_in;
   logic signed [31:0] turn_ff, turn_in;
   logic signed [16:0] cnt_ff [3];
   logic signed [16:0] cnt_in [3];
   logic signed [33:0] rot_ff, rot_in;
   logic signed [31:0] wvel_ff [3];
   logic signed [31:0] wvel_in [3];
   logic signed [31:0] target_ff [3];
   logic signed [31:0] target_in [3];
   logic signed [31:0] speed_ff [3];
   logic signed [31:0] speed_in [3];
   logic signed [31:0] integ_ff [3];
   logic signed [31:0] integ_in [3];
   logic signed [31:0] err_ff, err_in;
   logic signed [31:0] acc_ff, acc_in;
   logic signed [PROD_W-1:0] iterm_ff, iterm_in;
   logic signed [33:0] u_ff, u_in;
   logic               full_ff, full_in;
   logic [16:0]        duty_ff [3];
   logic [16:0]        duty_in [3];
   logic               dirw_ff [3];
   logic               dirw_in [3];

   logic               rsp_valid_ff, rsp_valid_in;
   logic [16:0]        out_duty_ff [3];
   logic [16:0]        out_duty_in [3];
   logic               out_dir_ff [3];
   logic               out_dir_in [3];
   logic signed [31:0] out_speed_ff [3];
   logic signed [31:0] out_speed_in [3];

   logic signed [PROD_W-1:0] wf_sum, wl_sum, wr_sum;
   logic signed [PROD_W-1:0] err_sum, acc_sum, u_sum, u_clamp;
   logic signed [31:0]       acc_new;
   logic signed [33:0]       mag;
   logic [16:0]              top_plus1;

   omdpi_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   omdpi_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign load_out  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign prod_sh16 = prod >>> 16;
   assign top_plus1 = 17'(cfg.pwm_top) + 17'd1;
   assign mag       = u_ff[33] ? -u_ff : u_ff;

   // Sequencer: state, step and wheel index.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      wheel_in = wheel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_KIN;
               step_in  = K_ROT;
            end
         end
         ST_KIN: begin
            if (step_ff == K_LAST) begin
               state_in = ST_WHEEL;
               step_in  = W_ERR;
               wheel_in = 2'd0;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_WHEEL: begin
            if (step_ff == W_LAST) begin
               step_in = W_ERR;
               if (wheel_ff == LAST_WHEEL) begin
                  state_in = ST_DONE;
               end else begin
                  wheel_in = wheel_ff + 2'd1;
               end
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= K_ROT;
         wheel_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         wheel_ff <= wheel_in;
      end
   end

   // Multiplier operand selection for each step.
   always_comb begin
      op_a = '0;
      op_b = '0;
      if (state_ff == ST_KIN) begin
         case (step_ff)
            K_ROT: begin
               op_a = MUL_W'(cfg.base_radius);
               op_b = MUL_W'(turn_ff);
            end
            K_SIDE: begin
               op_a = MUL_W'(COS30_Q16);
               op_b = MUL_W'(vy_ff);
            end
            K_TGT0: begin
               op_a = MUL_W'(wvel_ff[0]);
               op_b = MUL_W'(cfg.inv_wheel_circumference);
            end
            K_TGT1: begin
               op_a = MUL_W'(wvel_ff[1]);
               op_b = MUL_W'(cfg.inv_wheel_circumference);
            end
            K_TGT2: begin
               op_a = MUL_W'(wvel_ff[2]);
               op_b = MUL_W'(cfg.inv_wheel_circumference);
            end
            K_SPD0: begin
               op_a = MUL_W'(cnt_ff[0]);
               op_b = MUL_W'(cfg.count_scale);
            end
            K_SPD1: begin
               op_a = MUL_W'(cnt_ff[1]);
               op_b = MUL_W'(cfg.count_scale);
            end
            K_SPD2: begin
               op_a = MUL_W'(cnt_ff[2]);
               op_b = MUL_W'(cfg.count_scale);
            end
            default: ;
         endcase
      end else if (state_ff == ST_WHEEL) begin
         case (step_ff)
            W_ETP: begin
               op_a = MUL_W'(err_ff);
               op_b = MUL_W'(cfg.tick_period);
            end
            W_IP, W_ITERM: begin
               op_a = MUL_W'(acc_ff);
               op_b = MUL_W'(cfg.integ_gain);
            end
            W_PERR: begin
               op_a = MUL_W'(err_ff);
               op_b = MUL_W'(cfg.prop_gain);
            end
            W_DUTY: begin
               op_a = MUL_W'(mag[31:0]);
               op_b = MUL_W'(top_plus1);
            end
            default: ;
         endcase
      end
   end

   // Datapath: capture the word, then take each product as it comes back.
   always_comb begin
      vx_in     = vx_ff;
      vy_in     = vy_ff;
      turn_in   = turn_ff;
      cnt_in    = cnt_ff;
      rot_in    = rot_ff;
      wvel_in   = wvel_ff;
      target_in = target_ff;
      speed_in  = speed_ff;
      integ_in  = integ_ff;
      err_in    = err_ff;
      acc_in    = acc_ff;
      iterm_in  = iterm_ff;
      u_in      = u_ff;
      full_in   = full_ff;
      duty_in   = duty_ff;
      dirw_in   = dirw_ff;

      // Wheel velocities: front = -vx + rot, left/right = vx/2 -+ side + rot.
      wf_sum = -PROD_W'(vx_ff) + PROD_W'(rot_ff);
      wl_sum = PROD_W'(vx_ff >>> 1) - prod_sh16 + PROD_W'(rot_ff);
      wr_sum = PROD_W'(vx_ff >>> 1) + prod_sh16 + PROD_W'(rot_ff);

      err_sum = PROD_W'(target_ff[wheel_ff]) - PROD_W'(speed_ff[wheel_ff]);
      acc_sum = PROD_W'(integ_ff[wheel_ff]) + prod_sh16;

      // Anti-windup on integ_gain times the integrator.
      if (prod > ONE_Q32) begin
         acc_new = WINDUP_POS;
      end else if (prod < NEG_ONE_Q32) begin
         acc_new = WINDUP_NEG;
      end else begin
         acc_new = acc_ff;
      end

      // Drive, clamped to plus or minus one.
      u_sum = prod + iterm_ff;
      if (u_sum > ONE_Q32) begin
         u_clamp = ONE_Q32;
      end else if (u_sum < NEG_ONE_Q32) begin
         u_clamp = NEG_ONE_Q32;
      end else begin
         u_clamp = u_sum;
      end

      if (accept) begin
         vx_in     = req_cmd_vx;
         vy_in     = req_cmd_vy;
         turn_in   = req_cmd_turn;
         cnt_in[0] = -17'(req_count_front);
         cnt_in[1] = -17'(req_count_left);
         cnt_in[2] = 17'(req_count_right);
      end

      if (state_ff == ST_KIN) begin
         case (step_ff)
            K_SIDE: rot_in = prod_sh16[33:0];
            K_WVEL: begin
               wvel_in[0] = sat32(wf_sum);
               wvel_in[1] = sat32(wl_sum);
               wvel_in[2] = sat32(wr_sum);
            end
            K_TGT1: target_in[0] = sat32(prod_sh16);
            K_TGT2: target_in[1] = sat32(prod_sh16);
            K_SPD0: target_in[2] = sat32(prod_sh16);
            K_SPD1: speed_in[0] = sat32(prod);
            K_SPD2: speed_in[1] = sat32(prod);
            K_LAST: speed_in[2] = sat32(prod);
            default: ;
         endcase
      end else if (state_ff == ST_WHEEL) begin
         case (step_ff)
            W_ERR: err_in = sat32(err_sum);
            W_ACC: acc_in = sat32(acc_sum);
            W_WINDUP: begin
               acc_in             = acc_new;
               integ_in[wheel_ff] = acc_new;
            end
            W_PERR:  iterm_in = prod;
            W_DRIVE: u_in = u_clamp[33:0];
            W_DUTY: begin
               dirw_in[wheel_ff] = (u_ff > 34'sd0);
               full_in           = mag[32];
            end
            W_LAST: duty_in[wheel_ff] = full_ff ? top_plus1 : prod[48:32];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      vx_ff     <= vx_in;
      vy_ff     <= vy_in;
      turn_ff   <= turn_in;
      cnt_ff    <= cnt_in;
      rot_ff    <= rot_in;
      wvel_ff   <= wvel_in;
      target_ff <= target_in;
      speed_ff  <= speed_in;
      err_ff    <= err_in;
      acc_ff    <= acc_in;
      iterm_ff  <= iterm_in;
      u_ff      <= u_in;
      full_ff   <= full_in;
      duty_ff   <= duty_in;
      dirw_ff   <= dirw_in;
   end

   // Integrators are state carried between ticks.
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff[0] <= 32'sd0;
         integ_ff[1] <= 32'sd0;
         integ_ff[2] <= 32'sd0;
      end else begin
         integ_ff <= integ_in;
      end
   end

   // Output register: loaded when the tick is done and the slot is free.
   always_comb begin
      out_duty_in  = out_duty_ff;
      out_dir_in   = out_dir_ff;
      out_speed_in = out_speed_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_out) begin
         out_duty_in  = duty_ff;
         out_dir_in   = dirw_ff;
         out_speed_in = speed_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_duty_ff  <= out_duty_in;
      out_dir_ff   <= out_dir_in;
      out_speed_ff <= out_speed_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_duty_front  = out_duty_ff[0];
   assign rsp_dir_front   = out_dir_ff[0];
   assign rsp_duty_left   = out_duty_ff[1];
   assign rsp_dir_left    = out_dir_ff[1];
   assign rsp_duty_right  = out_duty_ff[2];
   assign rsp_dir_right   = out_dir_ff[2];
   assign rsp_speed_front = out_speed_ff[0];
   assign rsp_speed_left  = out_speed_ff[1];
   assign rsp_speed_right = out_speed_ff[2];

`ifndef SYNTHESIS
   // A taken word starts the kinematics at its first step.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_KIN && step_ff == K_ROT))
      else $error("sequencer did not start on a taken word");

   // A finished tick waits while the output slot is still occupied.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_DONE))
      else $error("result overwrote a stalled output word");

   // The wheel index stays within the three wheels.
   assert property (@(posedge clock) disable iff (reset)
      (wheel_ff != 2'd3))
      else $error("wheel index out of range");

   // No duty exceeds the PWM full scale.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_duty_front <= top_plus1 && rsp_duty_left <= top_plus1
                     && rsp_duty_right <= top_plus1))
      else $error("duty above PWM full scale");
`endif

endmodule

>>> tb/omni_drive_pi_motor_control_checker.sv
`timescale 1ns / 1ps

// Watches the command, result and register ports of the omni drive controller.
// It predicts every result word from its own copy of the PI loop state and
// compares the words that come out in order.
module omni_drive_pi_motor_control_checker
   import omdpi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_cmd_vx,
   input  logic signed [31:0] req_cmd_vy,
   input  logic signed [31:0] req_cmd_turn,
   input  logic signed [15:0] req_count_front,
   input  logic signed [15:0] req_count_left,
   input  logic signed [15:0] req_count_right,

   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [16:0]        rsp_duty_front,
   input  logic               rsp_dir_front,
   input  logic [16:0]        rsp_duty_left,
   input  logic               rsp_dir_left,
   input  logic [16:0]        rsp_duty_right,
   input  logic               rsp_dir_right,
   input  logic signed [31:0] rsp_speed_front,
   input  logic signed [31:0] rsp_speed_left,
   input  logic signed [31:0] rsp_speed_right,

   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   input  logic               csr_pready,

   output int                 error_count,
   output int                 pending_ticks
);

   // One in Q32.32, the limit of the drive and of the integral term.
   localparam longint UNITY_Q32 = 64'sd4294967296;

   typedef struct packed {
      logic [16:0] duty_front;
      logic        dir_front;
      logic [16:0] duty_left;
      logic        dir_left;
      logic [16:0] duty_right;
      logic        dir_right;
      logic [31:0] speed_front;
      logic [31:0] speed_left;
      logic [31:0] speed_right;
   } drive_word_type;

   // Shadow copy of the registers and the three wheel integrators.
   longint gain_p, gain_i, period, pwm_full, radius, inv_circ, cnt_scale;
   longint integ [3];

   drive_word_type predicted_drive_q[$];

   initial begin
      error_count = 0;
      pending_ticks = 0;
   end

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // Q16.16 product back to Q16.16, rounding toward minus infinity.
   function automatic longint floor_q16(input longint p);
      return p >>> 16;
   endfunction

   // One PI loop step for one wheel, with the anti-windup reload.
   function automatic void pi_wheel(input int idx, input longint target, input longint speed,
                                    output logic [16:0] duty, output logic dir);
      longint err, acc, ip, u, mag;
      err = clamp32(target - speed);
      acc = clamp32(integ[idx] + floor_q16(err * period));
      ip = gain_i * acc;
      if (ip > UNITY_Q32) begin
         acc = WINDUP_POS;
      end else if (ip < -UNITY_Q32) begin
         acc = WINDUP_NEG;
      end
      integ[idx] = acc;
      u = gain_p * err + gain_i * acc;
      if (u > UNITY_Q32) begin
         u = UNITY_Q32;
      end else if (u < -UNITY_Q32) begin
         u = -UNITY_Q32;
      end
      dir = (u > 0);
      mag = (u < 0) ? -u : u;
      duty = 17'((mag * pwm_full) >>> 32);
   endfunction

   // Inverse kinematics, count scaling and the three wheel loops for one tick.
   function automatic drive_word_type predict_drive(input longint vx, input longint vy,
                                                    input longint w, input longint cf,
                                                    input longint cl, input longint cr);
      drive_word_type r;
      longint rot, half, side, wf, wl, wr, tf, tl, tr, sf, sl, sr;
      rot = floor_q16(radius * w);
      half = floor_q16(64'sd32768 * vx);
      side = floor_q16(longint'(COS30_Q16) * vy);
      wf = clamp32(rot - vx);
      wl = clamp32(half - side + rot);
      wr = clamp32(half + side + rot);
      tf = clamp32(floor_q16(wf * inv_circ));
      tl = clamp32(floor_q16(wl * inv_circ));
      tr = clamp32(floor_q16(wr * inv_circ));
      sf = clamp32(cf * cnt_scale);
      sl = clamp32(cl * cnt_scale);
      sr = clamp32(cr * cnt_scale);
      pi_wheel(0, tf, sf, r.duty_front, r.dir_front);
      pi_wheel(1, tl, sl, r.duty_left, r.dir_left);
      pi_wheel(2, tr, sr, r.duty_right, r.dir_right);
      r.speed_front = 32'(sf);
      r.speed_left = 32'(sl);
      r.speed_right = 32'(sr);
      return r;
   endfunction

   // Register writes are masked to the width of the register.
   task automatic apply_write(input logic [2:0] idx, input logic [31:0] value);
      case (idx)
         REG_PROP_GAIN: begin
            gain_p = value[30:0];
         end
         REG_INTEG_GAIN: begin
            gain_i = value[30:0];
         end
         REG_TICK_PERIOD: begin
            period = value[15:0];
         end
         REG_PWM_TOP: begin
            pwm_full = longint'(value[15:0]) + 1;
         end
         REG_RADIUS: begin
            radius = value[15:0];
         end
         REG_INV_CIRC: begin
            inv_circ = value[30:0];
         end
         REG_COUNT_SCALE: begin
            cnt_scale = value[30:0];
         end
         default: begin
         end
      endcase
   endtask

   task automatic note_failure(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         note_failure($sformatf("%s got %h, expected %h", name, got, want));
      end
   endtask

   // Track registers, predict each accepted command word, check each result word.
   always @(posedge clock) begin
      drive_word_type exp_word;
      if (reset) begin
         gain_p = 65536;
         gain_i = 0;
         period = 655;
         pwm_full = 1000;
         radius = 6554;
         inv_circ = 327680;
         cnt_scale = 655;
         for (int k = 0; k < 3; k++) begin
            integ[k] = 0;
         end
         predicted_drive_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            apply_write(csr_paddr[4:2], csr_pwdata);
         end
         if (req_valid && !req_stall) begin
            predicted_drive_q.push_back(predict_drive(req_cmd_vx, req_cmd_vy, req_cmd_turn,
                                                      -longint'(req_count_front),
                                                      -longint'(req_count_left),
                                                      longint'(req_count_right)));
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_drive_q.size() == 0) begin
               note_failure("result word with no command word waiting");
            end else begin
               exp_word = predicted_drive_q.pop_front();
               check_field("duty_front", rsp_duty_front, exp_word.duty_front);
               check_field("dir_front", rsp_dir_front, exp_word.dir_front);
               check_field("duty_left", rsp_duty_left, exp_word.duty_left);
               check_field("dir_left", rsp_dir_left, exp_word.dir_left);
               check_field("duty_right", rsp_duty_right, exp_word.duty_right);
               check_field("dir_right", rsp_dir_right, exp_word.dir_right);
               check_field("speed_front", rsp_speed_front, exp_word.speed_front);
               check_field("speed_left", rsp_speed_left, exp_word.speed_left);
               check_field("speed_right", rsp_speed_right, exp_word.speed_right);
            end
         end
      end
      pending_ticks = predicted_drive_q.size();
   end

endmodule

>>> tb/omni_drive_pi_motor_control_tb.sv
`timescale 1ns / 1ps

module omni_drive_pi_motor_control_tb
   import omdpi_pkg::*;
();

   localparam logic [2:0] UNMAPPED_INDEX = 3'd7;
   localparam int QUIET_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 60;
   localparam int PHASE_TICKS = 230;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum int {SET_DEFAULT, SET_HIGHEST, SET_ZERO, SET_TYPICAL, SET_WILD} setting_kind_type;

   typedef struct packed {
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] turn;
      logic signed [15:0] cf;
      logic signed [15:0] cl;
      logic signed [15:0] cr;
   } tick_word_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [31:0] req_cmd_vx;
   logic signed [31:0] req_cmd_vy;
   logic signed [31:0] req_cmd_turn;
   logic signed [15:0] req_count_front;
   logic signed [15:0] req_count_left;
   logic signed [15:0] req_count_right;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [16:0]        rsp_duty_front;
   logic               rsp_dir_front;
   logic [16:0]        rsp_duty_left;
   logic               rsp_dir_left;
   logic [16:0]        rsp_duty_right;
   logic               rsp_dir_right;
   logic signed [31:0] rsp_speed_front;
   logic signed [31:0] rsp_speed_left;
   logic signed [31:0] rsp_speed_right;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [4:0]         csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   int mismatches;
   int in_flight;
   int send_idle_pct;
   int stall_pct;
   int quiet_cycles;

   omni_drive_pi_motor_control dut (.*);

   omni_drive_pi_motor_control_checker tick_check (
      .clock, .reset,
      .req_valid, .req_stall, .req_cmd_vx, .req_cmd_vy, .req_cmd_turn,
      .req_count_front, .req_count_left, .req_count_right,
      .rsp_valid, .rsp_stall, .rsp_duty_front, .rsp_dir_front, .rsp_duty_left,
      .rsp_dir_left, .rsp_duty_right, .rsp_dir_right,
      .rsp_speed_front, .rsp_speed_left, .rsp_speed_right,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .error_count(mismatches), .pending_ticks(in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The result side stalls at random, at the rate of the current phase.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // End the run when no word moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic tick_word_type make_word(input logic signed [31:0] vx,
                                               input logic signed [31:0] vy,
                                               input logic signed [31:0] turn,
                                               input logic signed [15:0] cf,
                                               input logic signed [15:0] cl,
                                               input logic signed [15:0] cr);
      tick_word_type w;
      w.vx = vx;
      w.vy = vy;
      w.turn = turn;
      w.cf = cf;
      w.cl = cl;
      w.cr = cr;
      return w;
   endfunction

   function automatic logic [31:0] pick_extreme32();
      case ($urandom_range(3))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [15:0] pick_extreme16();
      case ($urandom_range(3))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0;
         default: return 16'($urandom());
      endcase
   endfunction

   // Mostly plausible drive commands, some fully random words and some extremes.
   function automatic tick_word_type random_word();
      tick_word_type w;
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) begin
         w.vx = $urandom_range(0, 262144) - 32'd131072;
         w.vy = $urandom_range(0, 262144) - 32'd131072;
         w.turn = $urandom_range(0, 786432) - 32'd393216;
         w.cf = 16'($urandom_range(0, 600) - 300);
         w.cl = 16'($urandom_range(0, 600) - 300);
         w.cr = 16'($urandom_range(0, 600) - 300);
      end else if (roll < 85) begin
         w = {$urandom(), $urandom(), $urandom(), 16'($urandom()), 16'($urandom()),
              16'($urandom())};
      end else begin
         w = {pick_extreme32(), pick_extreme32(), pick_extreme32(), pick_extreme16(),
              pick_extreme16(), pick_extreme16()};
      end
      return w;
   endfunction

   function automatic cfg_type pick_setting(input setting_kind_type kind);
      cfg_type s;
      case (kind)
         SET_DEFAULT: begin
            s = '{31'd65536, 31'd0, 16'd655, 16'd999, 16'd6554, 31'd327680, 31'd655};
         end
         SET_HIGHEST: begin
            s = '1;
         end
         SET_ZERO: begin
            s = '0;
         end
         SET_TYPICAL: begin
            s.prop_gain = 31'($urandom_range(0, 8 * 65536));
            s.integ_gain = 31'($urandom_range(0, 40 * 65536));
            s.tick_period = 16'($urandom_range(1, 6554));
            s.pwm_top = 16'($urandom_range(99, 65535));
            s.base_radius = 16'($urandom_range(3000, 20000));
            s.inv_wheel_circumference = 31'($urandom_range(65536, 20 * 65536));
            s.count_scale = 31'($urandom_range(100, 3000));
         end
         default: begin
            s.prop_gain = 31'($urandom());
            s.integ_gain = 31'($urandom());
            s.tick_period = 16'($urandom());
            s.pwm_top = 16'($urandom());
            s.base_radius = 16'($urandom());
            s.inv_wheel_circumference = 31'($urandom());
            s.count_scale = 31'($urandom());
         end
      endcase
      return s;
   endfunction

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 61;
            stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            stall_pct = 61;
         end
         default: begin
            send_idle_pct = 32;
            stall_pct = 32;
         end
      endcase
   endtask

   // One register write: setup cycle, then access cycle until pready.
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Write every register with random bits above its width, then an unmapped one.
   task automatic program_setting(input cfg_type s);
      csr_write(REG_PROP_GAIN, ($urandom() & 32'h8000_0000) | 32'(s.prop_gain));
      csr_write(REG_INTEG_GAIN, ($urandom() & 32'h8000_0000) | 32'(s.integ_gain));
      csr_write(REG_TICK_PERIOD, ($urandom() & 32'hFFFF_0000) | 32'(s.tick_period));
      csr_write(REG_PWM_TOP, ($urandom() & 32'hFFFF_0000) | 32'(s.pwm_top));
      csr_write(REG_RADIUS, ($urandom() & 32'hFFFF_0000) | 32'(s.base_radius));
      csr_write(REG_INV_CIRC,
                ($urandom() & 32'h8000_0000) | 32'(s.inv_wheel_circumference));
      csr_write(REG_COUNT_SCALE, ($urandom() & 32'h8000_0000) | 32'(s.count_scale));
      csr_write(UNMAPPED_INDEX, $urandom());
   endtask

   // Offer one command word, after an optional gap, and hold it until taken.
   task automatic send_tick(input tick_word_type w);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 60)) @(negedge clock);
      end
      req_cmd_vx <= w.vx;
      req_cmd_vy <= w.vy;
      req_cmd_turn <= w.turn;
      req_count_front <= w.cf;
      req_count_left <= w.cl;
      req_count_right <= w.cr;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop sending and wait until every predicted result word has come back.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (in_flight != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      setting_kind_type plan [8];
      cfg_type s;
      plan = '{SET_TYPICAL, SET_HIGHEST, SET_TYPICAL, SET_ZERO, SET_TYPICAL, SET_WILD,
               SET_DEFAULT, SET_TYPICAL};
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd_vx = '0;
      req_cmd_vy = '0;
      req_cmd_turn = '0;
      req_count_front = '0;
      req_count_left = '0;
      req_count_right = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      set_idling(IDLE_NONE);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Field extremes under the reset settings; an all-zero word gives zero drive.
      send_tick(make_word(0, 0, 0, 0, 0, 0));
      send_tick(make_word(32'sh7FFF_FFFF, 0, 0, 0, 0, 0));
      send_tick(make_word(32'sh8000_0000, 0, 0, 0, 0, 0));
      send_tick(make_word(0, 32'sh7FFF_FFFF, 0, 0, 0, 0));
      send_tick(make_word(0, 32'sh8000_0000, 0, 0, 0, 0));
      send_tick(make_word(0, 0, 32'sh7FFF_FFFF, 0, 0, 0));
      send_tick(make_word(0, 0, 32'sh8000_0000, 0, 0, 0));
      send_tick(make_word(0, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000));
      send_tick(make_word(0, 0, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
      send_tick(make_word(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                          16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
      send_tick(make_word(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                          16'sh8000, 16'sh8000, 16'sh8000));
      send_tick(make_word(65536, 0, 0, 0, 0, 0));
      send_tick(make_word(0, 0, 0, 1, -1, 1));
      drain_results();

      // A strong integral gain drives the anti-windup reload both ways.
      s = pick_setting(SET_DEFAULT);
      s.integ_gain = 50 * 65536;
      s.tick_period = 6554;
      s.pwm_top = 16'hFFFF;
      program_setting(s);
      repeat (3) send_tick(make_word(65536, 0, 0, 0, 0, 0));
      repeat (3) send_tick(make_word(-65536, 0, 0, 0, 0, 0));
      send_tick(make_word(0, 0, 0, 0, 0, 0));
      send_tick(make_word(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0));
      send_tick(make_word(0, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000));
      drain_results();

      // Random phases, each with its own register setting and idling pattern.
      foreach (plan[p]) begin
         program_setting(pick_setting(plan[p]));
         for (int i = 0; i < PHASE_TICKS; i++) begin
            set_idling(idle_mode_type'((i / 58 + p) % 4));
            if (i == PHASE_TICKS / 2) begin
               drain_results();
            end
            send_tick(random_word());
         end
         drain_results();
      end

      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/omdpi_pkg.sv
rtl/core/omdpi_mul.sv
rtl/core/omdpi_csr.sv
rtl/core/omni_drive_pi_motor_control.sv
tb/omni_drive_pi_motor_control_checker.sv
tb/omni_drive_pi_motor_control_tb.sv
